### rtl/core/avc_length_prefix_to_start_code_defines.svh
// Assertion macros used by the checker file of the length-prefix converter.
`ifndef AVC_LENGTH_PREFIX_TO_START_CODE_DEFINES_SVH
`define AVC_LENGTH_PREFIX_TO_START_CODE_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define AVCL2S_ASSERT_NOW(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (prop)) \
      else $error(msg);

// Property that must hold in the cycle after its trigger.
`define AVCL2S_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

### rtl/core/avcl2s_pkg.sv
// Types and constants of the length-prefix to start-code converter.
`default_nettype none
package avcl2s_pkg;

   localparam int RecordCountBitsDefault = 24;
   localparam int LeftW = 24;

   localparam logic [LeftW-1:0] CfgMinBytes   = LeftW'(6);
   localparam logic [2:0]       LenSizeDefault = 3'd4;
   localparam logic [2:0]       ParamLenSize   = 3'd2;
   localparam logic [2:0]       HdrIdxLenSize  = 3'd4;
   localparam logic [2:0]       HdrIdxSpsCount = 3'd5;
   localparam logic [7:0]       SpsCountMask   = 8'h1f;
   localparam logic [7:0]       StartCodeZero  = 8'h00;
   localparam logic [7:0]       StartCodeOne   = 8'h01;
   localparam logic [1:0]       StartCodeLast  = 2'd3;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_NAL_BIG   = 2'd1,
      KIND_CFG_SHORT = 2'd2
   } result_kind_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_CFG_HEAD  = 4'd1,
      PH_LEN_FRAME = 4'd2,
      PH_PAY_FRAME = 4'd3,
      PH_LEN_SPS   = 4'd4,
      PH_PAY_SPS   = 4'd5,
      PH_PPS_COUNT = 4'd6,
      PH_LEN_PPS   = 4'd7,
      PH_PAY_PPS   = 4'd8,
      PH_SKIP      = 4'd9
   } phase_type;

   // One entry of the output queue: a single result or a four-byte start code.
   typedef struct packed {
      logic            start;
      logic [7:0]      data;
      result_kind_type kind;
   } desc_type;

endpackage
`default_nettype wire

### rtl/core/avc_length_prefix_to_start_code.sv
// Top level: converts length-prefixed NAL records to a start-code byte stream.
//
//  channel | dir | tdata                          | tuser                         | tlast
//  req_    | in  | [7:0] in_byte, [31:8] bytes_left | [0] first_of_record, [1] kind | -
//  rsp_    | out | [7:0] out_byte                 | [1:0] result_kind, [2] start  | last_of_run
//
//  An input item is parsed in the cycle it is accepted; the parser state is
//  updated at once and its results enter a two-entry output queue.
//  One item per cycle while req_tready is high; an item that ends a length
//  field puts a start code in the output register until its four bytes are taken.
//  reset is synchronous and clears the parser and both queue entries.
//  req_tready drops only while the second queue entry is occupied.
`default_nettype none
module avc_length_prefix_to_start_code
   import avcl2s_pkg::*;
#(
   parameter int RECORD_COUNT_BITS = RecordCountBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [7:0] in_byte, [31:8] bytes_left
   input  wire logic [1:0]  req_tuser,   // [0] first_of_record, [1] record_kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic [2:0]       rsp_tuser,   // [1:0] result_kind, [2] is_start_code
   output logic             rsp_tlast
);

   localparam int CntW = (RECORD_COUNT_BITS < LeftW) ? RECORD_COUNT_BITS : LeftW;
   localparam logic [LeftW-1:0] LeftMask = LeftW'((33'(1) << CntW) - 33'(1));

   // parser state
   phase_type        phase_ff, phase_in;
   logic [2:0]       lfs_ff, lfs_in;
   logic [31:0]      acc_ff, acc_in;
   logic [2:0]       lbs_ff, lbs_in;
   logic [LeftW-1:0] pay_ff, pay_in;
   logic [2:0]       hidx_ff, hidx_in;
   logic [7:0]       psl_ff, psl_in;

   // output queue
   logic       act_valid_ff, act_valid_in;
   desc_type   act_ff, act_in;
   logic [1:0] beat_ff, beat_in;
   logic       pend_valid_ff, pend_valid_in;
   desc_type   pend_ff, pend_in;

   logic             accept;
   logic [7:0]       b;
   logic [LeftW-1:0] left;
   logic             first;
   logic             cfg;
   logic             emit;
   desc_type         new_desc;
   logic             done;
   logic [2:0]       size;
   logic             finishing;
   logic             act_free;

   assign req_tready = !pend_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata[7:0];
   assign first      = req_tuser[0];
   assign cfg        = req_tuser[1];

   always_comb begin
      left = req_tdata[31:8] & LeftMask;
      if (left == '0) begin
         left = LeftW'(1);
      end
   end

   always_comb begin
      phase_in = phase_ff;
      lfs_in   = lfs_ff;
      acc_in   = acc_ff;
      lbs_in   = lbs_ff;
      pay_in   = pay_ff;
      hidx_in  = hidx_ff;
      psl_in   = psl_ff;
      emit     = 1'b0;
      new_desc = '{start: 1'b0, data: 8'h00, kind: KIND_DATA};
      done     = 1'b0;
      size     = ParamLenSize;

      if (first) begin
         lbs_in  = '0;
         acc_in  = '0;
         pay_in  = '0;
         hidx_in = '0;
         psl_in  = '0;
         if (cfg) begin
            if (left < CfgMinBytes) begin
               emit          = 1'b1;
               new_desc.kind = KIND_CFG_SHORT;
               phase_in      = PH_SKIP;
            end else begin
               phase_in = PH_CFG_HEAD;
            end
         end else begin
            phase_in = PH_LEN_FRAME;
         end
      end

      case (phase_in)
         PH_CFG_HEAD: begin
            if (hidx_in == HdrIdxLenSize) begin
               lfs_in = 3'(b[1:0]) + 3'd1;
            end
            if (hidx_in == HdrIdxSpsCount) begin
               psl_in   = b & SpsCountMask;
               phase_in = (psl_in != '0) ? PH_LEN_SPS : PH_PPS_COUNT;
               lbs_in   = '0;
            end
            hidx_in = hidx_in + 3'd1;
         end
         PH_LEN_FRAME, PH_LEN_SPS, PH_LEN_PPS: begin
            size = (phase_in == PH_LEN_FRAME) ? lfs_in : ParamLenSize;
            if (lbs_in == '0 && LeftW'(size) > left) begin
               // length field would run past the record end
               phase_in = PH_SKIP;
            end else begin
               if (lbs_in == '0) begin
                  acc_in = '0;
               end
               acc_in = {acc_in[23:0], b};
               lbs_in = lbs_in + 3'd1;
               if (lbs_in >= size) begin
                  lbs_in = '0;
                  emit   = 1'b1;
                  if (acc_in > 32'(left - LeftW'(1))) begin
                     new_desc.kind = KIND_NAL_BIG;
                     phase_in      = PH_SKIP;
                  end else begin
                     new_desc.start = 1'b1;
                     pay_in         = acc_in[LeftW-1:0];
                     if (acc_in == '0) begin
                        done = 1'b1;
                     end else begin
                        case (phase_in)
                           PH_LEN_FRAME: phase_in = PH_PAY_FRAME;
                           PH_LEN_SPS:   phase_in = PH_PAY_SPS;
                           default:      phase_in = PH_PAY_PPS;
                        endcase
                     end
                  end
               end
            end
         end
         PH_PAY_FRAME, PH_PAY_SPS, PH_PAY_PPS: begin
            emit          = 1'b1;
            new_desc.data = b;
            pay_in        = pay_in - LeftW'(1);
            done          = (pay_in == '0);
         end
         PH_PPS_COUNT: begin
            psl_in   = b;
            phase_in = (b != '0) ? PH_LEN_PPS : PH_SKIP;
            lbs_in   = '0;
         end
         default: begin
         end
      endcase

      // unit fully emitted: pick what follows it
      if (done) begin
         case (phase_in)
            PH_LEN_FRAME, PH_PAY_FRAME: phase_in = PH_LEN_FRAME;
            PH_LEN_SPS, PH_PAY_SPS: begin
               psl_in   = psl_in - 8'd1;
               phase_in = (psl_in != '0) ? PH_LEN_SPS : PH_PPS_COUNT;
            end
            default: begin
               psl_in   = psl_in - 8'd1;
               phase_in = (psl_in != '0) ? PH_LEN_PPS : PH_SKIP;
            end
         endcase
         lbs_in = '0;
         acc_in = '0;
      end

      if (left <= LeftW'(1)) begin
         phase_in = PH_IDLE;
      end
   end

   // output side
   assign rsp_tvalid = act_valid_ff;
   assign rsp_tdata  = act_ff.start ?
                       ((beat_ff == StartCodeLast) ? StartCodeOne : StartCodeZero) : act_ff.data;
   assign rsp_tuser  = {act_ff.start, act_ff.start ? KIND_DATA : act_ff.kind};
   assign rsp_tlast  = !act_ff.start || (beat_ff == StartCodeLast);
   assign finishing  = act_valid_ff && rsp_tready && rsp_tlast;
   assign act_free   = !act_valid_ff || finishing;

   always_comb begin
      act_valid_in  = act_valid_ff;
      act_in        = act_ff;
      beat_in       = beat_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (act_valid_ff && rsp_tready && !rsp_tlast) begin
         beat_in = beat_ff + 2'd1;
      end
      if (act_free) begin
         beat_in = '0;
         if (pend_valid_ff) begin
            act_valid_in  = 1'b1;
            act_in        = pend_ff;
            pend_valid_in = 1'b0;
         end else if (accept && emit) begin
            act_valid_in = 1'b1;
            act_in       = new_desc;
         end else begin
            act_valid_in = 1'b0;
         end
      end else if (accept && emit) begin
         pend_valid_in = 1'b1;
         pend_in       = new_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         lfs_ff        <= LenSizeDefault;
         acc_ff        <= '0;
         lbs_ff        <= '0;
         pay_ff        <= '0;
         hidx_ff       <= '0;
         psl_ff        <= '0;
         act_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         beat_ff       <= '0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            lfs_ff   <= lfs_in;
            acc_ff   <= acc_in;
            lbs_ff   <= lbs_in;
            pay_ff   <= pay_in;
            hidx_ff  <= hidx_in;
            psl_ff   <= psl_in;
         end
         act_valid_ff  <= act_valid_in;
         pend_valid_ff <= pend_valid_in;
         beat_ff       <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      pend_ff <= pend_in;
   end

endmodule
`default_nettype wire

### rtl/core/avcl2s_checker.sv
// Port-level checker for the length-prefix converter, bound to the top level.
`default_nettype none
`include "avc_length_prefix_to_start_code_defines.svh"
module avcl2s_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   logic in_unused;
   assign in_unused = req_tvalid ^ req_tready ^ (^req_tdata) ^ (^req_tuser);

   // a stalled result holds
   `AVCL2S_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // status results are single, zero-valued items
   `AVCL2S_ASSERT_NOW(a_status_last, rsp_tvalid && rsp_tuser[1:0] != 2'd0, rsp_tlast && rsp_tdata == 8'h00 && !rsp_tuser[2], "status result malformed")

   // a start code continues until its final 01 byte
   `AVCL2S_ASSERT_NEXT(a_sc_cont, rsp_tvalid && rsp_tready && rsp_tuser[2] && !rsp_tlast, rsp_tvalid && rsp_tuser[2] && rsp_tuser[1:0] == 2'd0, "start code cut short")

   // start code bytes are 00 except the last, which is 01
   `AVCL2S_ASSERT_NOW(a_sc_value, rsp_tvalid && rsp_tuser[2], (rsp_tlast && rsp_tdata == 8'h01) || (!rsp_tlast && rsp_tdata == 8'h00), "bad start code byte")

endmodule

bind avc_length_prefix_to_start_code avcl2s_checker u_checker (.*);
`default_nettype wire
